// ===== rtl/core/caldate_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared widths, calendar constants, operation codes and the month and
// leap year helper functions.
// ----------------------------------------------------------------------------
package caldate_pkg;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  CUTOVER_YEAR = YEAR_W'(1916);
    localparam logic [YEAR_W-1:0]  MAX_YEAR     = YEAR_W'(9999);
    localparam logic [DAY_W-1:0]   CUTOVER_DAY  = DAY_W'(14);
    localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_MAR    = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MONTH_APR    = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);

    // Reciprocal of 25 scaled by 2^20, rounded up; exact for 14-bit years
    localparam int                 RECIP_SHIFT  = 20;
    localparam logic [15:0]        RECIP_25     = 16'd41944;
    localparam int                 PROD_W       = YEAR_W + 16;
    localparam int                 QUOT_W       = PROD_W - RECIP_SHIFT;

    // Operation codes carried in the input tuser
    typedef enum logic [0:0] {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    // True when the year is a multiple of 25 (quotient by reciprocal product)
    function automatic logic div_by_25(input logic [YEAR_W-1:0] year);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        logic [PROD_W-1:0] back;
        prod = PROD_W'(year) * PROD_W'(RECIP_25);
        quot = prod[PROD_W-1:RECIP_SHIFT];
        back = PROD_W'(quot) * PROD_W'(25);
        return back == PROD_W'(year);
    endfunction

    // Julian rule up to the cutover year, Gregorian rule after it
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic div4;
        logic div16;
        logic div25;
        div4  = (year[1:0] == 2'b00);
        div16 = (year[3:0] == 4'b0000);
        div25 = div_by_25(year);
        if (year <= CUTOVER_YEAR) begin
            return div4;
        end
        return (div4 && !div25) || (div16 && div25);
    endfunction

    // Length of a month; zero for a month code out of range
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] days;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    days = DAY_W'(30);
            4'd2:    days = leap ? DAY_W'(29) : DAY_W'(28);
            default: days = '0;
        endcase
        return days;
    endfunction

endpackage

// ===== rtl/core/calendar_date_counter_core.sv =====
// ----------------------------------------------------------------------------
// Calendar date counter core
// Holds a date with valid and leap flags; a tick transaction advances it by
// one day and a load transaction stores and checks a given date.
// ----------------------------------------------------------------------------
// Every input transaction produces exactly one result transaction carrying the
// date after that transaction. One transaction is taken per clock cycle while
// the result side does not stall: the next date is formed in combinational
// logic (month length lookup, day and month increment, two constant multiplies
// for the divisible-by-25 test) and written straight into the date registers,
// which also drive the result port. A new transaction is accepted whenever the
// result register is empty or is being taken in the same cycle.
module calendar_date_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // load_day[4:0], load_month[8:5], load_year[22:9]
    input  logic [0:0]  i_s_tuser,  // operation[0]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                    // date_valid[23], leap_year[24]
);

    localparam int DW = caldate_pkg::DAY_W;
    localparam int MW = caldate_pkg::MONTH_W;
    localparam int YW = caldate_pkg::YEAR_W;

    // Date state, which is also the result payload
    logic [DW-1:0] r_day,   n_day;
    logic [MW-1:0] r_month, n_month;
    logic [YW-1:0] r_year,  n_year;
    logic          r_valid, n_valid;
    logic          r_leap,  n_leap;
    logic          r_out_vld;

    // Input fields
    logic          in_acc;
    logic          op_load;
    logic [DW-1:0] ld_day;
    logic [MW-1:0] ld_month;
    logic [YW-1:0] ld_year;
    logic [DW-1:0] cur_len;
    logic [DW-1:0] ld_len;

    assign o_s_tready = !r_out_vld || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign op_load    = (i_s_tuser[0] == caldate_pkg::OP_LOAD);
    assign ld_day     = i_s_tdata[4:0];
    assign ld_month   = i_s_tdata[8:5];
    assign ld_year    = i_s_tdata[22:9];

    // Next date for a tick or a load; the leap flag follows the next year
    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_valid = r_valid;
        cur_len = caldate_pkg::month_days(r_month, r_leap);
        if (op_load) begin
            n_day   = ld_day;
            n_month = ld_month;
            n_year  = ld_year;
        end else if (r_valid) begin
            if (r_year == caldate_pkg::CUTOVER_YEAR && r_month == caldate_pkg::MONTH_MAR
                && r_day == DW'(31)) begin
                // Skip over the days dropped at the calendar change
                n_day   = caldate_pkg::CUTOVER_DAY;
                n_month = caldate_pkg::MONTH_APR;
            end else if (r_day < cur_len) begin
                n_day = r_day + DW'(1);
            end else if (r_month < caldate_pkg::MONTH_DEC) begin
                n_day   = DW'(1);
                n_month = r_month + MW'(1);
            end else if (r_year < caldate_pkg::MAX_YEAR) begin
                n_day   = DW'(1);
                n_month = caldate_pkg::MONTH_JAN;
                n_year  = r_year + YW'(1);
            end
        end
        n_leap = caldate_pkg::is_leap(n_year);
        ld_len = caldate_pkg::month_days(ld_month, n_leap);
        if (op_load) begin
            n_valid = (ld_len != '0) && (ld_day != '0) && (ld_day <= ld_len)
                   && (ld_year != '0)
                   && !(ld_year == caldate_pkg::CUTOVER_YEAR
                        && ld_month == caldate_pkg::MONTH_APR
                        && ld_day < caldate_pkg::CUTOVER_DAY);
        end
    end

    // Date registers and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day     <= DW'(1);
            r_month   <= MW'(1);
            r_year    <= YW'(1);
            r_valid   <= 1'b1;
            r_leap    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
                r_valid <= n_valid;
                r_leap  <= n_leap;
            end
            if (in_acc) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_leap, r_valid, r_year, r_month, r_day};

    // A valid date always has a month in range and a nonzero day
    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_month >= MW'(1) && r_month <= MW'(12) && r_day != '0))
        else $error("valid date with month or day out of range");

    // A tick on an invalid date leaves the date unchanged
    a_invalid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !op_load && !r_valid) |=>
            ($stable(r_day) && $stable(r_month) && $stable(r_year) && !r_valid))
        else $error("tick changed an invalid date");

    // A leap year is always a multiple of four
    a_leap_div4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leap |-> (r_year[1:0] == 2'b00))
        else $error("leap flag set on a year not divisible by four");

    // No result is lost: a pending result that is not taken blocks new input
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted over a pending result");

endmodule

// ===== tb/calendar_date_counter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter core testbench
// Sends tick and load transactions with random gaps and result stalls. Each
// accepted transaction updates a local copy of the date, and the expected
// date, valid flag and leap flag are queued. Every result transaction is then
// compared field by field with the oldest queued date.
// ----------------------------------------------------------------------------
module calendar_date_counter_core_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int REPORT_MAX   = 10;

    localparam int DW = caldate_pkg::DAY_W;
    localparam int MW = caldate_pkg::MONTH_W;
    localparam int YW = caldate_pkg::YEAR_W;

    // Date after one transaction, as the result port carries it (lowest last)
    typedef struct packed {
        logic          leap;
        logic          valid;
        logic [YW-1:0] year;
        logic [MW-1:0] month;
        logic [DW-1:0] day;
    } t_date_result;

    // Tracks the date register and checks the results against it
    class t_date_scoreboard;
        logic [DW-1:0] day_q;
        logic [MW-1:0] month_q;
        logic [YW-1:0] year_q;
        logic          valid_q;
        t_date_result  expected_dates[$];
        int            failures;

        function new();
            day_q    = DW'(1);
            month_q  = MW'(1);
            year_q   = YW'(1);
            valid_q  = 1'b1;
            failures = 0;
        endfunction

        // Julian rule up to the cutover year, Gregorian rule after it
        function logic leap_of(logic [YW-1:0] y);
            if (y <= caldate_pkg::CUTOVER_YEAR) begin
                return (y % 4) == 0;
            end
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function logic [DW-1:0] length_of(logic [MW-1:0] m, logic [YW-1:0] y);
            case (m)
                1, 3, 5, 7, 8, 10, 12:  return DW'(31);
                4, 6, 9, 11:            return DW'(30);
                caldate_pkg::MONTH_FEB: return leap_of(y) ? DW'(29) : DW'(28);
                default:                return '0;
            endcase
        endfunction

        function logic date_ok(logic [DW-1:0] d, logic [MW-1:0] m, logic [YW-1:0] y);
            if (m < caldate_pkg::MONTH_JAN || m > caldate_pkg::MONTH_DEC) begin
                return 1'b0;
            end
            if (d == '0 || d > length_of(m, y) || y == '0) begin
                return 1'b0;
            end
            // The skipped days of the cutover April
            if (y == caldate_pkg::CUTOVER_YEAR && m == caldate_pkg::MONTH_APR
                && d < caldate_pkg::CUTOVER_DAY) begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void advance_day();
            if (!valid_q) begin
                return;
            end
            if (year_q == caldate_pkg::CUTOVER_YEAR && month_q == caldate_pkg::MONTH_MAR
                && day_q == DW'(31)) begin
                day_q   = caldate_pkg::CUTOVER_DAY;
                month_q = caldate_pkg::MONTH_APR;
            end else if (day_q < length_of(month_q, year_q)) begin
                day_q = day_q + DW'(1);
            end else if (month_q < caldate_pkg::MONTH_DEC) begin
                day_q   = DW'(1);
                month_q = month_q + MW'(1);
            end else if (year_q < caldate_pkg::MAX_YEAR) begin
                // The last year holds on 31 December instead of wrapping
                day_q   = DW'(1);
                month_q = caldate_pkg::MONTH_JAN;
                year_q  = year_q + YW'(1);
            end
        endfunction

        // Applies one accepted input transaction and queues the date after it
        function void predict_date(caldate_pkg::t_op op, logic [DW-1:0] d,
                                   logic [MW-1:0] m, logic [YW-1:0] y);
            t_date_result next_date;
            if (op == caldate_pkg::OP_LOAD) begin
                day_q   = d;
                month_q = m;
                year_q  = y;
                valid_q = date_ok(d, m, y);
            end else begin
                advance_day();
            end
            next_date.day   = day_q;
            next_date.month = month_q;
            next_date.year  = year_q;
            next_date.valid = valid_q;
            next_date.leap  = leap_of(year_q);
            expected_dates.push_back(next_date);
        endfunction

        function void check_date_result(logic [31:0] data);
            t_date_result seen;
            t_date_result want;
            seen = data[24:0];
            if (expected_dates.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("ERROR: unexpected result %0d/%0d/%0d valid %0b leap %0b",
                             seen.day, seen.month, seen.year, seen.valid, seen.leap);
                end
                return;
            end
            want = expected_dates.pop_front();
            if (seen.day !== want.day || seen.month !== want.month ||
                seen.year !== want.year || seen.valid !== want.valid ||
                seen.leap !== want.leap) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $write("ERROR: date mismatch, expected %0d/%0d/%0d valid %0b leap %0b",
                           want.day, want.month, want.year, want.valid, want.leap);
                    $display(", got %0d/%0d/%0d valid %0b leap %0b",
                             seen.day, seen.month, seen.year, seen.valid, seen.leap);
                end
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;  // load_day[4:0], load_month[8:5], load_year[22:9]
    logic [0:0]  i_s_tuser  = '0;  // operation[0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // cur_day[4:0], cur_month[8:5], cur_year[22:9],
                                   // date_valid[23], leap_year[24]

    t_date_scoreboard board = new();
    bit               quiet = 1'b0;
    int unsigned      stall_left = 0;
    int unsigned      stall_draw;
    int unsigned      items_sent = 0;
    int unsigned      cycle_count = 0;

    calendar_date_counter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 0;
    end

    // Idle length: mostly none or short, sometimes long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Years around the leap rules, the cutover and the range top, zero and over 9999
    function automatic logic [YW-1:0] pick_year();
        int unsigned r;
        int unsigned special[14];
        special = '{1, 4, 100, 1600, 1700, 1900, 1915, 1916, 1917, 2000, 2100, 2400,
                    9998, 9999};
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return YW'(special[$urandom_range(0, 13)]);
        end else if (r < 35) begin
            return YW'($urandom_range(10000, 16383));
        end else if (r < 38) begin
            return '0;
        end
        return YW'($urandom_range(1, 9999));
    endfunction

    // Drives one input transaction and waits until it is accepted
    task automatic send_item(input caldate_pkg::t_op op, input logic [DW-1:0] d,
                             input logic [MW-1:0] m, input logic [YW-1:0] y);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {1'b0, y, m, d};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        board.predict_date(op, d, m, y);
        items_sent++;
    endtask

    task automatic load_date(input int d, input int m, input int y);
        send_item(caldate_pkg::OP_LOAD, DW'(d), MW'(m), YW'(y));
    endtask

    // Tick transactions carry random load fields, which must be ignored
    task automatic tick_days(input int unsigned n);
        repeat (n) begin
            send_item(caldate_pkg::OP_TICK, DW'($urandom), MW'($urandom), YW'($urandom));
        end
    endtask

    // Result side: check accepted results and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_date_result(o_m_tdata);
        end
        if (quiet) begin
            i_m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            stall_draw = pick_gap();
            i_m_tready <= (stall_draw == 0);
            stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned   random_start;
        int unsigned   kind;
        logic [MW-1:0] m;
        logic [YW-1:0] y;
        logic [DW-1:0] len;
        logic [DW-1:0] d;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: leap rules, cutover jump, year hold, invalid loads
        tick_days(1);
        load_date(31, 3, 1916);
        tick_days(1);
        load_date(13, 4, 1916);
        tick_days(1);
        load_date(14, 4, 1916);
        load_date(29, 2, 1900);
        load_date(29, 2, 1600);
        tick_days(1);
        load_date(28, 2, 2100);
        tick_days(1);
        load_date(29, 2, 2000);
        tick_days(1);
        load_date(31, 12, 9999);
        tick_days(1);
        load_date(31, 12, 16383);
        tick_days(1);
        load_date(1, 1, 0);
        tick_days(1);
        load_date(0, 1, 2000);
        load_date(31, 4, 2001);
        load_date(31, 15, 0);
        load_date(31, 0, 2000);
        load_date(31, 12, 1916);
        tick_days(1);

        // Random part: mostly valid dates near a month end followed by ticks
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 7) == 0);
            kind  = $urandom_range(0, 9);
            if (kind == 0) begin
                send_item(caldate_pkg::OP_LOAD, DW'($urandom), MW'($urandom),
                          YW'($urandom));
                tick_days($urandom_range(0, 3));
            end else if (kind == 8) begin
                load_date($urandom_range(24, 31), 12, int'(pick_year()));
                tick_days($urandom_range(0, 12));
            end else if (kind == 9) begin
                if ($urandom_range(0, 1) == 1) begin
                    load_date($urandom_range(25, 31), 3, int'(caldate_pkg::CUTOVER_YEAR));
                end else begin
                    load_date($urandom_range(8, 16), 4, int'(caldate_pkg::CUTOVER_YEAR));
                end
                tick_days($urandom_range(0, 10));
            end else begin
                y   = pick_year();
                m   = MW'($urandom_range(1, 12));
                len = board.length_of(m, y);
                d   = ($urandom_range(0, 9) == 0) ? DW'(31)
                                                  : len - DW'($urandom_range(0, 3));
                send_item(caldate_pkg::OP_LOAD, d, m, y);
                tick_days($urandom_range(0, 40));
            end
        end
        quiet = 1'b0;
        i_s_tvalid <= 1'b0;

        // Drain the outstanding results
        while (board.expected_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (board.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
